@@ rtl/subset_dp_longest_chain_defines.svh @@
// Assertion macros shared by the block's modules.
`ifndef SUBSET_DP_LONGEST_CHAIN_DEFINES_SVH
`define SUBSET_DP_LONGEST_CHAIN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDLC_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDLC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sdlc_pkg.sv @@
`default_nettype none

package sdlc_pkg;

    localparam int KEY_W   = 32;
    localparam int LEN_W   = 5;
    localparam int REM_W   = 4;
    localparam logic [LEN_W-1:0] REM_MAX = 5'd15;

    typedef struct packed {
        logic load;
        logic init;
        logic issue;
        logic finish;
        logic report;
    } sdlc_cmd_t;

    typedef struct packed {
        logic j_last;
        logic mask_last;
    } sdlc_stat_t;

endpackage

`default_nettype wire

@@ rtl/sdlc_ctrl.sv @@
`default_nettype none

module sdlc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              last_item,
    output logic                   busy,
    output logic                   done,
    output sdlc_pkg::sdlc_cmd_t    cmd,
    input  wire sdlc_pkg::sdlc_stat_t stat
);

`include "subset_dp_longest_chain_defines.svh"

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_FINISH = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_item)
                    begin
                        cmd.init   = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (stat.j_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = stat.mask_last ? ST_REPORT : ST_RUN;
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_REPORT);

    `SDLC_ASSERT_NEXT(a_done_frees, clk, rst_n, done, !busy, "Block stays busy after a result.")
    `SDLC_ASSERT_NEXT(a_load_only, clk, rst_n, start && !busy && !last_item, !busy, "Plain load made the block busy.")

endmodule

`default_nettype wire

@@ rtl/sdlc_dpath.sv @@
`default_nettype none

module sdlc_dpath #(
    parameter int MAX_ITEMS = 16,
    parameter int KEY_BITS  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sdlc_pkg::sdlc_cmd_t           cmd,
    output sdlc_pkg::sdlc_stat_t               stat,
    input  wire logic [sdlc_pkg::KEY_W-1:0]    first_key,
    input  wire logic [sdlc_pkg::KEY_W-1:0]    second_key,
    output logic [sdlc_pkg::LEN_W-1:0]         longest_chain,
    output logic [sdlc_pkg::REM_W-1:0]         items_removed,
    output logic                               overflow
);

`include "subset_dp_longest_chain_defines.svh"

    localparam int MW    = MAX_ITEMS;
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int JW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CMP_W = (KEY_BITS < sdlc_pkg::KEY_W) ? KEY_BITS : sdlc_pkg::KEY_W;
    localparam int DEPTH = 1 << MAX_ITEMS;

    // Chain-end sets, one word per subset mask.
    logic [MW-1:0]    ends_mem [DEPTH];
    logic [MW-1:0]    rd_data_reg;

    logic [CMP_W-1:0] kf_reg [MAX_ITEMS];
    logic [CMP_W-1:0] ks_reg [MAX_ITEMS];
    logic [MW-1:0]    adj_reg [MAX_ITEMS];

    logic [CW-1:0]    count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [MW-1:0]    mask_reg, mask_next;
    logic [JW-1:0]    j_reg, j_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [JW-1:0]    rd_j_reg, rd_j_next;
    logic [MW-1:0]    acc_reg, acc_next;
    logic [CW-1:0]    pop_reg, pop_next;
    logic [CW-1:0]    best_reg, best_next;

    logic [CMP_W-1:0] k1;
    logic [CMP_W-1:0] k2;
    logic [MW-1:0]    match;
    logic             room;
    logic [MW-1:0]    full_mask;
    logic [MW-1:0]    rd_addr;
    logic [MW-1:0]    rd_onehot;
    logic             end_bit;
    logic [MW-1:0]    contrib;
    logic [MW-1:0]    ends_final;
    logic [CW-1:0]    count_m1;
    logic [sdlc_pkg::LEN_W-1:0] diff;

    assign k1   = first_key[CMP_W-1:0];
    assign k2   = second_key[CMP_W-1:0];
    assign room = (count_reg < CW'(MAX_ITEMS));

    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            match[i] = (CW'(i) < count_reg) && ((kf_reg[i] == k1) || (ks_reg[i] == k2));
        end
    end

    assign full_mask = ~({MW{1'b1}} << count_reg);
    assign count_m1  = count_reg - 1'b1;
    assign rd_addr   = mask_reg ^ (MW'(1) << j_reg);
    assign rd_onehot = MW'(1) << rd_j_reg;

    // An item ends a chain over the mask if the mask is just that item, or if some
    // chain over the mask without it ends at a compatible item.
    assign end_bit = (mask_reg == rd_onehot) ||
                     (mask_reg[rd_j_reg] && (|(rd_data_reg & adj_reg[rd_j_reg])));
    assign contrib    = (rd_vld_reg && end_bit) ? rd_onehot : '0;
    assign ends_final = acc_reg | contrib;

    assign stat.j_last    = (CW'(j_reg) == count_m1);
    assign stat.mask_last = (mask_reg == full_mask);

    always_comb
    begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        mask_next   = mask_reg;
        j_next      = j_reg;
        rd_vld_next = 1'b0;
        rd_j_next   = rd_j_reg;
        acc_next    = acc_reg;
        pop_next    = pop_reg;
        best_next   = best_reg;

        if (cmd.load)
        begin
            if (room)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.init)
        begin
            mask_next = MW'(1);
            j_next    = '0;
            acc_next  = '0;
            pop_next  = '0;
            best_next = '0;
        end
        if (cmd.issue)
        begin
            rd_vld_next = 1'b1;
            rd_j_next   = j_reg;
            j_next      = stat.j_last ? '0 : j_reg + 1'b1;
            pop_next    = pop_reg + CW'(mask_reg[j_reg]);
            acc_next    = ends_final;
        end
        if (cmd.finish)
        begin
            mask_next = mask_reg + 1'b1;
            acc_next  = '0;
            pop_next  = '0;
            if ((ends_final != '0) && (pop_reg > best_reg))
            begin
                best_next = pop_reg;
            end
        end
        if (cmd.report)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            mask_reg   <= '0;
            j_reg      <= '0;
            rd_vld_reg <= 1'b0;
            rd_j_reg   <= '0;
            acc_reg    <= '0;
            pop_reg    <= '0;
            best_reg   <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            mask_reg   <= mask_next;
            j_reg      <= j_next;
            rd_vld_reg <= rd_vld_next;
            rd_j_reg   <= rd_j_next;
            acc_reg    <= acc_next;
            pop_reg    <= pop_next;
            best_reg   <= best_next;
        end
    end

    // Key stores and the compatibility matrix, filled one item per load.
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            kf_reg[count_reg[JW-1:0]]  <= k1;
            ks_reg[count_reg[JW-1:0]]  <= k2;
            adj_reg[count_reg[JW-1:0]] <= match;
            for (int i = 0; i < MAX_ITEMS; i++)
            begin
                if (CW'(i) < count_reg)
                begin
                    adj_reg[i][count_reg[JW-1:0]] <= match[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_data_reg <= ends_mem[rd_addr];
        end
        if (cmd.finish)
        begin
            ends_mem[mask_reg] <= ends_final;
        end
    end

    assign diff          = sdlc_pkg::LEN_W'(count_reg) - sdlc_pkg::LEN_W'(best_reg);
    assign longest_chain = sdlc_pkg::LEN_W'(best_reg);
    assign items_removed = (diff > sdlc_pkg::REM_MAX) ? sdlc_pkg::REM_MAX[sdlc_pkg::REM_W-1:0]
                                                      : diff[sdlc_pkg::REM_W-1:0];
    assign overflow      = ovf_reg;

    `SDLC_ASSERT_NEXT(a_write_gap, clk, rst_n, cmd.finish, !cmd.finish, "Two mask writes in a row.")
    `SDLC_ASSERT_NOW(a_fin_data, clk, rst_n, cmd.finish, rd_vld_reg, "Mask closed without its last read.")
    `SDLC_ASSERT_NOW(a_best_range, clk, rst_n, cmd.report, (best_reg != '0) && (best_reg <= count_reg), "Chain length out of range.")

endmodule

`default_nettype wire

@@ rtl/subset_dp_longest_chain.sv @@
// Channel   Handshake          Fields                               Width
// input     start, busy        first_key, second_key, last_item     32, 32, 1
// result    done (strobe)      longest_chain, items_removed,        5, 4, 1
//                              overflow
//
// Each item that is not marked last is loaded while busy stays low.
// The last item starts the search over the n loaded items: every subset mask
// is visited once, with one read of the chain-end memory per item and one
// write to close the mask.
// The chain-end memory needs no clearing pass, since every mask is written
// before any larger mask reads it; reset is asynchronous and clears control state.
// The result is shown for one cycle with done high and cannot be stalled.
`default_nettype none

module subset_dp_longest_chain #(
    parameter int MAX_ITEMS = 16,
    parameter int KEY_BITS  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [sdlc_pkg::KEY_W-1:0]    first_key,
    input  wire logic [sdlc_pkg::KEY_W-1:0]    second_key,
    input  wire logic                          last_item,
    output logic                               done,
    output logic [sdlc_pkg::LEN_W-1:0]         longest_chain,
    output logic [sdlc_pkg::REM_W-1:0]         items_removed,
    output logic                               overflow
);

    sdlc_pkg::sdlc_cmd_t  cmd;
    sdlc_pkg::sdlc_stat_t stat;

    sdlc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_item (last_item),
        .busy      (busy),
        .done      (done),
        .cmd       (cmd),
        .stat      (stat)
    );

    sdlc_dpath #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .first_key     (first_key),
        .second_key    (second_key),
        .longest_chain (longest_chain),
        .items_removed (items_removed),
        .overflow      (overflow)
    );

endmodule

`default_nettype wire

@@ sim/tb_subset_dp_longest_chain.sv @@
`timescale 1ns / 100ps

module tb_subset_dp_longest_chain;

    localparam int CAPACITY = 16;
    localparam int KW       = sdlc_pkg::KEY_W;

    typedef struct packed {
        logic [sdlc_pkg::LEN_W-1:0] len;
        logic [sdlc_pkg::REM_W-1:0] removed;
        logic                       ovf;
    } chain_result_t;

    typedef struct packed {
        logic [KW-1:0] k1;
        logic [KW-1:0] k2;
        logic          last;
        logic          typed;
        chain_result_t want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [KW-1:0]              first_key;
    logic [KW-1:0]              second_key;
    logic                       last_item;
    logic                       done;
    logic [sdlc_pkg::LEN_W-1:0] longest_chain;
    logic [sdlc_pkg::REM_W-1:0] items_removed;
    logic                       overflow;

    logic [KW-1:0]  stored_first [CAPACITY];
    logic [KW-1:0]  stored_second [CAPACITY];
    int             loaded_count = 0;
    bit             overflow_flag = 1'b0;
    chain_result_t  pending_chain_results[$];
    chain_result_t  oldest_result;
    int             mismatches = 0;

    subset_dp_longest_chain #(
        .MAX_ITEMS(CAPACITY),
        .KEY_BITS (KW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .first_key    (first_key),
        .second_key   (second_key),
        .last_item    (last_item),
        .done         (done),
        .longest_chain(longest_chain),
        .items_removed(items_removed),
        .overflow     (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic chain_result_t solve_longest_chain();
        logic [15:0]   adj [CAPACITY];
        bit [15:0]     ends_at [];
        logic [15:0]   reach;
        int            n;
        int            total;
        int            best;
        int            diff;
        chain_result_t r;
        n = loaded_count;
        total = 1 << n;
        ends_at = new[total];
        for (int i = 0; i < n; i++)
        begin
            adj[i] = '0;
            for (int j = 0; j < n; j++)
                if (stored_first[i] == stored_first[j] || stored_second[i] == stored_second[j])
                    adj[i][j] = 1'b1;
        end
        for (int i = 0; i < n; i++)
            ends_at[1 << i] = 16'(1) << i;
        best = 0;
        for (int mask = 1; mask < total; mask++)
        begin
            if (ends_at[mask] == '0)
                continue;
            if ($countones(mask) > best)
                best = $countones(mask);
            reach = '0;
            for (int i = 0; i < n; i++)
                if (ends_at[mask][i])
                    reach |= adj[i];
            reach &= ~mask[15:0];
            for (int j = 0; j < n; j++)
                if (reach[j])
                    ends_at[mask | (1 << j)][j] = 1'b1;
        end
        diff = n - best;
        r.len = best[sdlc_pkg::LEN_W-1:0];
        r.removed = (diff > 15) ? 4'd15 : diff[sdlc_pkg::REM_W-1:0];
        r.ovf = overflow_flag;
        return r;
    endfunction

    function automatic bit take_item(input logic [KW-1:0] k1, input logic [KW-1:0] k2,
                                     input logic last, output chain_result_t r);
        r = '0;
        if (loaded_count < CAPACITY)
        begin
            stored_first[loaded_count] = k1;
            stored_second[loaded_count] = k2;
            loaded_count++;
        end
        else
            overflow_flag = 1'b1;
        if (!last)
            return 1'b0;
        r = solve_longest_chain();
        loaded_count = 0;
        overflow_flag = 1'b0;
        return 1'b1;
    endfunction

    task automatic drive_item(input stim_row_t row);
        chain_result_t r;
        bit            produced;
        start <= 1'b1;
        first_key <= row.k1;
        second_key <= row.k2;
        last_item <= row.last;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        produced = take_item(row.k1, row.k2, row.last, r);
        if (produced)
            pending_chain_results = {pending_chain_results, (row.typed ? row.want : r)};
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
            start <= 1'b0;
        for (int c = 0; c < cycles; c++)
        begin
            first_key <= $urandom;
            second_key <= $urandom;
            last_item <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_chain_results.size() != 0);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_chain_results.size() == 0)
                report_mismatch($sformatf("unexpected result %0d/%0d/%0d",
                                          longest_chain, items_removed, overflow));
            else
            begin
                oldest_result = pending_chain_results.pop_front();
                if (longest_chain !== oldest_result.len)
                    report_mismatch($sformatf("longest_chain %0d, wanted %0d",
                                              longest_chain, oldest_result.len));
                if (items_removed !== oldest_result.removed)
                    report_mismatch($sformatf("items_removed %0d, wanted %0d",
                                              items_removed, oldest_result.removed));
                if (overflow !== oldest_result.ovf)
                    report_mismatch($sformatf("overflow %0d, wanted %0d",
                                              overflow, oldest_result.ovf));
            end
        end
    end

    initial
    begin
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        stim_row_t     rows[$];
        stim_row_t     row;
        stim_row_t     fixed_rows [11];
        logic [KW-1:0] pool_a [3];
        logic [KW-1:0] pool_b [3];
        int            set_size;
        int            rand_items;
        int            rand_sets;
        bit            burst;

        fixed_rows = '{
            '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, '{5'd1, 4'd0, 1'b0}},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '{5'd1, 4'd0, 1'b0}},
            '{32'h0000_1234, 32'h0000_0001, 1'b0, 1'b0, '{5'd0, 4'd0, 1'b0}},
            '{32'h0000_1234, 32'h0000_0002, 1'b1, 1'b1, '{5'd2, 4'd0, 1'b0}},
            '{32'h0000_0007, 32'h55AA_55AA, 1'b0, 1'b0, '{5'd0, 4'd0, 1'b0}},
            '{32'h0000_0008, 32'h55AA_55AA, 1'b1, 1'b1, '{5'd2, 4'd0, 1'b0}},
            '{32'h0000_0005, 32'h0000_0006, 1'b0, 1'b0, '{5'd0, 4'd0, 1'b0}},
            '{32'h0000_0007, 32'h0000_0008, 1'b1, 1'b1, '{5'd1, 4'd1, 1'b0}},
            '{32'h0000_0001, 32'h0000_000A, 1'b0, 1'b0, '{5'd0, 4'd0, 1'b0}},
            '{32'h0000_0001, 32'h0000_0014, 1'b0, 1'b0, '{5'd0, 4'd0, 1'b0}},
            '{32'h0000_0003, 32'h0000_0014, 1'b1, 1'b0, '{5'd0, 4'd0, 1'b0}}
        };

        rst_n <= 1'b0;
        start <= 1'b0;
        first_key <= '0;
        second_key <= '0;
        last_item <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (fixed_rows[idx])
            rows = {rows, fixed_rows[idx]};
        for (int i = 0; i <= CAPACITY; i++)
        begin
            row.k1 = 32'h0000_1000 + i;
            row.k2 = 32'hFFFF_F000 - i;
            row.last = (i == CAPACITY);
            row.typed = (i == CAPACITY);
            row.want = '{5'd1, 4'd15, 1'b1};
            rows = {rows, row};
        end

        foreach (rows[idx])
        begin
            drive_item(rows[idx]);
            idle_gap(pick_gap());
        end
        wait_drained();

        rand_items = 0;
        rand_sets = 0;
        while (rand_items < 112 || rand_sets < 30)
        begin
            set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10)
                                                   : $urandom_range(1, 6);
            burst = ($urandom_range(0, 3) == 0);
            for (int p = 0; p < 3; p++)
            begin
                pool_a[p] = $urandom;
                pool_b[p] = $urandom;
            end
            for (int k = 0; k < set_size; k++)
            begin
                row.k1 = $urandom_range(0, 3) != 0 ? pool_a[$urandom_range(0, 2)] : $urandom;
                row.k2 = $urandom_range(0, 3) != 0 ? pool_b[$urandom_range(0, 2)] : $urandom;
                row.last = (k == set_size - 1);
                row.typed = 1'b0;
                row.want = '0;
                drive_item(row);
                rand_items++;
                if (!burst)
                    idle_gap(pick_gap());
            end
            rand_sets++;
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sdlc_pkg.sv
rtl/sdlc_ctrl.sv
rtl/sdlc_dpath.sv
rtl/subset_dp_longest_chain.sv
sim/tb_subset_dp_longest_chain.sv
